// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros for the core RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/lpsd_pkg.sv =====
package lpsd_pkg;

  // Board geometry
  localparam int NUM_REGS      = 3;
  localparam int COLUMN_LENGTH = 12;
  localparam int PHASES        = 16;
  localparam int NUM_COLS      = 2;
  localparam int BITS_PER_REG  = 8;
  localparam int LED_COUNT     = NUM_REGS * BITS_PER_REG;

  // Widths
  localparam int LEVEL_W   = 4;
  localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int PHASE_W   = $clog2(PHASES);
  localparam int CMP_W     = (PHASE_W > LEVEL_W) ? PHASE_W : LEVEL_W;
  localparam int COORD_W   = 8;

  // Reset values
  localparam logic [LEVEL_W-1:0] GLOBAL_RESET    = 4'd8;
  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RESET = 4'd1;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET = 4'd15;

  // Configuration register indexes
  localparam logic CFG_MIN_LEVEL = 1'b0;
  localparam logic CFG_MAX_LEVEL = 1'b1;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_SET_ONOFF  = 2'd1,
    FUNC_SET_LEVEL  = 2'd2,
    FUNC_SET_GLOBAL = 2'd3
  } lpsd_func_e;

  // Input tdata layout, lowest bit last in the list
  typedef struct packed {
    logic [4:0]         pad;
    logic [LEVEL_W-1:0] level;
    logic               turn_on;
    logic [1:0]         col;
    logic [3:0]         row;
  } lpsd_in_data_t;

  // Output tdata layout
  typedef struct packed {
    logic [1:0] pad;
    logic [4:0] bit_index;
    logic       serial_bit;
  } lpsd_out_data_t;

  // Frame hand-off from the sequencer to the serializer
  typedef struct packed {
    logic                 start;
    logic [LED_COUNT-1:0] pattern;
  } lpsd_frame_req_t;

endpackage

// ===== rtl/core/lpsd_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// A read of the address being written returns the old contents.
module lpsd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 24
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lpsd_frame_out.sv =====
`include "assert_macros.svh"

// Frame serializer: holds one pattern and sends it LED by LED, highest
// index first, through an output register that decouples the sink.
module lpsd_frame_out (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lpsd_pkg::lpsd_frame_req_t req_i,
  output logic                     busy_o,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,  // serial_bit, bit_index[4:0], zero pad
  output logic                     m_axis_tlast   // latch
);

  logic [lpsd_pkg::LED_COUNT-1:0]  pat_q, pat_d;
  logic [lpsd_pkg::LED_IDX_W-1:0]  cnt_q, cnt_d;
  logic                            active_q, active_d;
  logic                            out_valid_q, out_valid_d;
  lpsd_pkg::lpsd_out_data_t        out_data_q, out_data_d;
  logic                            out_last_q, out_last_d;
  logic                            load;

  // Load a new word when a bit is pending and the output slot frees up
  assign load = active_q && (!out_valid_q || m_axis_tready);

  always_comb begin
    pat_d       = pat_q;
    cnt_d       = cnt_q;
    active_d    = active_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;

    // Drop the word once it is taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    // Advance to the next LED, stop after LED 0
    if (load) begin
      out_valid_d           = 1'b1;
      out_data_d.pad        = '0;
      out_data_d.bit_index  = 5'(cnt_q);
      out_data_d.serial_bit = pat_q[cnt_q];
      out_last_d            = (cnt_q == '0);
      if (cnt_q == '0) begin
        active_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end

    // Capture a new frame
    if (req_i.start) begin
      pat_d    = req_i.pattern;
      cnt_d    = lpsd_pkg::LED_IDX_W'(lpsd_pkg::LED_COUNT - 1);
      active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q      <= pat_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign busy_o        = active_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `ASSERT_IMPLIES(a_start_idle, req_i.start, !active_q, "frame started while serializer busy")
  `ASSERT_IMPLIES(a_cnt_range, active_q, cnt_q <= lpsd_pkg::LED_IDX_W'(lpsd_pkg::LED_COUNT - 1), "serializer index out of range")
  `ASSERT_NEXT(a_last_word, load && (cnt_q == '0), !active_q && m_axis_tvalid && m_axis_tlast, "last word did not end the frame")

endmodule

// ===== rtl/core/led_pwm_shift_out_driver.sv =====
// Channel  Direction  Handshake                      Contents
// s_axis   in         s_axis_tvalid / s_axis_tready  command word: kind in tuser, LED and level
// m_axis   out        m_axis_tvalid / m_axis_tready  one shifted bit, LED index, latch in tlast
// cfg      in         cfg_valid_i / cfg_ready_o      min_level (0), max_level (1)
//
// Set on/off and set level write the level memory in the cycle they are accepted. Set global
// level and a tick both sweep the 24-entry level memory through its single read port,
// one entry a cycle, then drain the last read (and a tick then compares the pattern).
// A changed pattern leaves as 24 words, one per cycle while the sink accepts them; a further
// changed tick waits in its compare step until that frame has entered the output register.
// Reset clears control state; valid bits zero the level memory. Config never stalls.
`include "assert_macros.svh"

module led_pwm_shift_out_driver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // row[3:0], col[1:0], turn_on, level[3:0], zero pad
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // serial_bit, bit_index[4:0], zero pad
  output logic        m_axis_tlast,   // latch
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_data_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_CMP   = 2'd3;

  logic [1:0]                           state_q, state_d;
  logic                                 is_tick_q, is_tick_d;
  logic [lpsd_pkg::LED_IDX_W-1:0]       cnt_q, cnt_d;
  logic                                 rd_pend_q, rd_pend_d;
  logic [lpsd_pkg::LED_IDX_W-1:0]       rd_addr_q, rd_addr_d;
  logic                                 rd_valid_q, rd_valid_d;
  logic [lpsd_pkg::LED_COUNT-1:0]       valid_q, valid_d;
  logic [lpsd_pkg::LED_COUNT-1:0]       sent_q, sent_d;
  logic [lpsd_pkg::LED_COUNT-1:0]       pat_q, pat_d;
  logic [lpsd_pkg::PHASE_W-1:0]         phase_q, phase_d;
  logic [lpsd_pkg::LEVEL_W-1:0]         glob_q, glob_d;
  logic [lpsd_pkg::LEVEL_W-1:0]         min_q, min_d;
  logic [lpsd_pkg::LEVEL_W-1:0]         max_q, max_d;

  logic                                 ram_we;
  logic [lpsd_pkg::LED_IDX_W-1:0]       ram_waddr;
  logic [lpsd_pkg::LEVEL_W-1:0]         ram_wdata;
  logic [lpsd_pkg::LED_IDX_W-1:0]       ram_raddr;
  logic [lpsd_pkg::LEVEL_W-1:0]         ram_rdata;
  logic [lpsd_pkg::LEVEL_W-1:0]         rd_level;

  lpsd_pkg::lpsd_in_data_t              in_data;
  lpsd_pkg::lpsd_func_e                 in_func;
  logic                                 in_accept;
  logic [lpsd_pkg::COORD_W-1:0]         led_sum;
  logic                                 led_ok;
  logic [lpsd_pkg::LED_IDX_W-1:0]       led_idx;
  logic [lpsd_pkg::LEVEL_W-1:0]         clamp_level;
  logic [lpsd_pkg::PHASE_W-1:0]         phase_next;

  lpsd_pkg::lpsd_frame_req_t            frame_req;
  logic                                 frame_busy;

  assign in_data       = lpsd_pkg::lpsd_in_data_t'(s_axis_tdata);
  assign in_func       = lpsd_pkg::lpsd_func_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Map row and column to an LED index and check it
  assign led_sum = in_data.col[0]
                 ? lpsd_pkg::COORD_W'(in_data.row) + lpsd_pkg::COORD_W'(lpsd_pkg::COLUMN_LENGTH)
                 : lpsd_pkg::COORD_W'(in_data.row);
  assign led_ok  = (lpsd_pkg::COORD_W'(in_data.row) < lpsd_pkg::COORD_W'(lpsd_pkg::COLUMN_LENGTH))
                && (in_data.col < 2'(lpsd_pkg::NUM_COLS))
                && (led_sum < lpsd_pkg::COORD_W'(lpsd_pkg::LED_COUNT));
  assign led_idx = led_sum[lpsd_pkg::LED_IDX_W-1:0];

  // Clamp the global level: above the ceiling gives the ceiling, else below the floor gives the floor
  assign clamp_level = (in_data.level > max_q) ? max_q
                     : (in_data.level < min_q) ? min_q
                     : in_data.level;

  // Unwritten entries read as zero
  assign rd_level = rd_valid_q ? ram_rdata : '0;

  assign phase_next = (phase_q == lpsd_pkg::PHASE_W'(lpsd_pkg::PHASES - 1))
                    ? '0 : phase_q + 1'b1;

  // Sequencer: config writes, direct level writes, memory sweeps and frame compare
  always_comb begin
    state_d         = state_q;
    is_tick_d       = is_tick_q;
    cnt_d           = cnt_q;
    rd_pend_d       = 1'b0;
    rd_addr_d       = rd_addr_q;
    rd_valid_d      = rd_valid_q;
    valid_d         = valid_q;
    sent_d          = sent_q;
    pat_d           = pat_q;
    phase_d         = phase_q;
    glob_d          = glob_q;
    min_d           = min_q;
    max_d           = max_q;
    ram_we          = 1'b0;
    ram_waddr       = led_idx;
    ram_wdata       = '0;
    ram_raddr       = cnt_q;
    frame_req.start   = 1'b0;
    frame_req.pattern = pat_q;

    // Configuration writes
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lpsd_pkg::CFG_MIN_LEVEL: min_d = cfg_data_i;
        lpsd_pkg::CFG_MAX_LEVEL: max_d = cfg_data_i;
        default: ;
      endcase
    end

    // Handle the word returned by the previous read
    if (rd_pend_q) begin
      if (is_tick_q) begin
        pat_d[rd_addr_q] = lpsd_pkg::CMP_W'(rd_level) > lpsd_pkg::CMP_W'(phase_q);
      end else if (rd_level != '0) begin
        ram_we    = 1'b1;
        ram_waddr = rd_addr_q;
        ram_wdata = glob_q;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_func)
            lpsd_pkg::FUNC_SET_ONOFF: begin
              if (led_ok) begin
                ram_we           = 1'b1;
                ram_wdata        = in_data.turn_on ? glob_q : '0;
                valid_d[led_idx] = 1'b1;
                sent_d[led_idx]  = in_data.turn_on;
              end
            end
            lpsd_pkg::FUNC_SET_LEVEL: begin
              if (led_ok && (in_data.level <= max_q)) begin
                ram_we           = 1'b1;
                ram_wdata        = in_data.level;
                valid_d[led_idx] = 1'b1;
                sent_d[led_idx]  = (in_data.level != '0);
              end
            end
            lpsd_pkg::FUNC_SET_GLOBAL: begin
              glob_d    = clamp_level;
              is_tick_d = 1'b0;
              cnt_d     = '0;
              state_d   = ST_SWEEP;
            end
            lpsd_pkg::FUNC_TICK: begin
              pat_d     = '0;
              is_tick_d = 1'b1;
              cnt_d     = '0;
              state_d   = ST_SWEEP;
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        // Issue one read a cycle across the level memory
        rd_pend_d  = 1'b1;
        rd_addr_d  = cnt_q;
        rd_valid_d = valid_q[cnt_q];
        if (cnt_q == lpsd_pkg::LED_IDX_W'(lpsd_pkg::LED_COUNT - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = is_tick_q ? ST_CMP : ST_IDLE;
      end
      ST_CMP: begin
        // Send only a changed pattern, hold until the serializer is free
        if (pat_q == sent_q) begin
          phase_d = phase_next;
          state_d = ST_IDLE;
        end else if (!frame_busy) begin
          frame_req.start = 1'b1;
          sent_d          = pat_q;
          phase_d         = phase_next;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      is_tick_q <= 1'b0;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      valid_q   <= '0;
      sent_q    <= '0;
      phase_q   <= '0;
      glob_q    <= lpsd_pkg::GLOBAL_RESET;
      min_q     <= lpsd_pkg::MIN_LEVEL_RESET;
      max_q     <= lpsd_pkg::MAX_LEVEL_RESET;
    end else begin
      state_q   <= state_d;
      is_tick_q <= is_tick_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= rd_pend_d;
      valid_q   <= valid_d;
      sent_q    <= sent_d;
      phase_q   <= phase_d;
      glob_q    <= glob_d;
      min_q     <= min_d;
      max_q     <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q  <= rd_addr_d;
    rd_valid_q <= rd_valid_d;
    pat_q      <= pat_d;
  end

  lpsd_ram #(
    .WIDTH (lpsd_pkg::LEVEL_W),
    .DEPTH (lpsd_pkg::LED_COUNT)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lpsd_frame_out u_frame_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (frame_req),
    .busy_o        (frame_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  `ASSERT_IMPLIES(a_sweep_write, ram_we && (state_q != ST_IDLE), rd_pend_q && (ram_waddr == rd_addr_q), "sweep wrote an entry it did not read")
  `ASSERT_IMPLIES(a_rd_range, rd_pend_q, rd_addr_q < lpsd_pkg::LED_IDX_W'(lpsd_pkg::LED_COUNT), "read address beyond the last LED")
  `ASSERT_NEXT(a_frame_taken, frame_req.start, frame_busy && (state_q == ST_IDLE), "frame start not picked up")

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 445;
  localparam int NUM_PHASES    = 5;

  // One shifted LED bit as it should leave the block
  typedef struct packed {
    logic                 serial;
    logic [4:0]           led;
    logic                 last;
  } shift_bit_t;

  // Directed stimulus: a register write or a command, with the frame typed in where obvious
  typedef struct {
    bit                             cfg;
    logic                           cfg_idx;
    lpsd_pkg::lpsd_func_e           func;
    logic [3:0]                     row;
    logic [1:0]                     col;
    logic                           on;
    logic [3:0]                     level;
    bit                             typed;
    bit                             frame;
    logic [lpsd_pkg::LED_COUNT-1:0] pat;
  } script_row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // row[3:0], col[1:0], turn_on, level[3:0], zero pad
  logic [1:0]  s_axis_tuser  = '0;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // serial_bit, bit_index[4:0], zero pad
  logic        m_axis_tlast;         // latch
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i   = 1'b0;
  logic [3:0]  cfg_data_i    = '0;

  // Shadow of the driver state
  logic [lpsd_pkg::LEVEL_W-1:0]   led_level [lpsd_pkg::LED_COUNT];
  logic [lpsd_pkg::LED_COUNT-1:0] shown_pattern = '0;
  logic [lpsd_pkg::PHASE_W-1:0]   pwm_pos       = '0;
  logic [lpsd_pkg::LEVEL_W-1:0]   global_lvl    = lpsd_pkg::GLOBAL_RESET;
  logic [lpsd_pkg::LEVEL_W-1:0]   floor_lvl     = lpsd_pkg::MIN_LEVEL_RESET;
  logic [lpsd_pkg::LEVEL_W-1:0]   ceil_lvl      = lpsd_pkg::MAX_LEVEL_RESET;

  shift_bit_t  pending_bits [$];
  script_row_t script [$];
  int          mismatches = 0;
  bit          quiet      = 1'b0;

  led_pwm_shift_out_driver u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    foreach (led_level[i]) led_level[i] = '0;
  end

  // Advance the shadow state by one command; report a frame when a tick changes the pattern
  function automatic void apply_command(input lpsd_pkg::lpsd_func_e f, input logic [3:0] r,
                                        input logic [1:0] c, input logic on,
                                        input logic [3:0] lv, output logic fired,
                                        output logic [lpsd_pkg::LED_COUNT-1:0] pat);
    int         led;
    bit         valid;
    logic [3:0] g;
    fired = 1'b0;
    pat   = '0;
    led   = int'(r) + int'(c) * lpsd_pkg::COLUMN_LENGTH;
    valid = (int'(r) < lpsd_pkg::COLUMN_LENGTH) && (int'(c) < lpsd_pkg::NUM_COLS)
         && (led < lpsd_pkg::LED_COUNT);
    case (f)
      lpsd_pkg::FUNC_SET_ONOFF: begin
        if (valid) begin
          led_level[led]     = on ? global_lvl : '0;
          shown_pattern[led] = on;
        end
      end
      lpsd_pkg::FUNC_SET_LEVEL: begin
        if (valid && lv <= ceil_lvl) begin
          led_level[led]     = lv;
          shown_pattern[led] = (lv != 0);
        end
      end
      lpsd_pkg::FUNC_SET_GLOBAL: begin
        g = lv;
        if (g > ceil_lvl) g = ceil_lvl;
        else if (g < floor_lvl) g = floor_lvl;
        global_lvl = g;
        foreach (led_level[i]) if (led_level[i] != 0) led_level[i] = g;
      end
      default: begin
        foreach (led_level[i]) pat[i] = (led_level[i] > pwm_pos);
        if (pat != shown_pattern) begin
          shown_pattern = pat;
          fired         = 1'b1;
        end
        pwm_pos = lpsd_pkg::PHASE_W'((int'(pwm_pos) + 1) % lpsd_pkg::PHASES);
      end
    endcase
  endfunction

  // Offer one command word, wait for acceptance, queue its frame bits
  task automatic send_cmd(input lpsd_pkg::lpsd_func_e f, input logic [3:0] r,
                          input logic [1:0] c, input logic on, input logic [3:0] lv,
                          input bit typed, input bit frame_typed,
                          input logic [lpsd_pkg::LED_COUNT-1:0] pat_typed);
    lpsd_pkg::lpsd_in_data_t        w;
    logic                           fired;
    logic [lpsd_pkg::LED_COUNT-1:0] pat;
    w         = '0;
    w.row     = r;
    w.col     = c;
    w.turn_on = on;
    w.level   = lv;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_command(f, r, c, on, lv, fired, pat);
    if (typed) begin
      fired = frame_typed;
      pat   = pat_typed;
    end
    if (fired) begin
      for (int b = lpsd_pkg::LED_COUNT - 1; b >= 0; b--)
        pending_bits.push_back(shift_bit_t'{pat[b], 5'(b), (b == 0)});
    end
    // Drop valid for a random burst now and then
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Hold off until every queued bit has arrived and the block has gone quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; the caller drops cfg_valid_i afterwards
  task automatic write_reg(input logic idx, input logic [3:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == lpsd_pkg::CFG_MIN_LEVEL) floor_lvl = data;
    else ceil_lvl = data;
  endtask

  // Randomly stall the output side
  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Compare every accepted word with the oldest queued bit
  always @(posedge clk_i) begin
    lpsd_pkg::lpsd_out_data_t got;
    shift_bit_t               want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_bits.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual serial=%b index=%0d latch=%b",
                 $time, got.serial_bit, got.bit_index, m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_bits.pop_front();
        if (got.serial_bit !== want.serial) begin
          $display("%0t: serial_bit: expected %b, actual %b (index %0d)",
                   $time, want.serial, got.serial_bit, want.led);
          mismatches++;
        end
        if (got.bit_index !== want.led) begin
          $display("%0t: bit_index: expected %0d, actual %0d", $time, want.led,
                   got.bit_index);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: latch: expected %b, actual %b (index %0d)", $time, want.last,
                   m_axis_tlast, want.led);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    logic [3:0]            lo_plan [NUM_PHASES];
    logic [3:0]            hi_plan [NUM_PHASES];
    lpsd_pkg::lpsd_func_e  f;
    logic [3:0]            r;
    logic [1:0]            c;
    logic                  on;
    logic [3:0]            lv;
    int                    pick;
    int                    per_phase;

    // Directed commands from reset state
    script.push_back('{0, 0, lpsd_pkg::FUNC_TICK,       0,  0, 0, 0,  1, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_ONOFF,  0,  0, 1, 0,  1, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_TICK,       0,  0, 0, 0,  1, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_LEVEL,  11, 1, 0, 15, 1, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_LEVEL,  0,  1, 0, 0,  1, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_ONOFF,  12, 0, 1, 0,  1, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_ONOFF,  15, 3, 1, 0,  1, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_LEVEL,  5,  2, 0, 5,  1, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_GLOBAL, 0,  0, 0, 15, 1, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_GLOBAL, 0,  0, 0, 0,  1, 0, '0});
    // Level 1 drops out at phase 2: an all-dark frame goes out
    script.push_back('{0, 0, lpsd_pkg::FUNC_TICK,       0,  0, 0, 0,  1, 1, 24'h000000});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_GLOBAL, 0,  0, 0, 9,  1, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_ONOFF,  3,  1, 1, 0,  1, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_TICK,       0,  0, 0, 0,  1, 1, 24'h808001});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_ONOFF,  0,  0, 0, 0,  1, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_TICK,       0,  0, 0, 0,  1, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_LEVEL,  7,  0, 0, 15, 1, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_TICK,       0,  0, 0, 0,  1, 0, '0});
    // Lower the ceiling: levels above it are rejected, min above max clamps
    script.push_back('{1, lpsd_pkg::CFG_MAX_LEVEL, lpsd_pkg::FUNC_TICK, 0, 0, 0, 9, 0, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_LEVEL,  2,  0, 0, 12, 0, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_LEVEL,  2,  0, 0, 9,  0, 0, '0});
    script.push_back('{1, lpsd_pkg::CFG_MIN_LEVEL, lpsd_pkg::FUNC_TICK, 0, 0, 0, 12, 0, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_GLOBAL, 0,  0, 0, 3,  0, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_TICK,       0,  0, 0, 0,  0, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_SET_GLOBAL, 0,  0, 0, 15, 0, 0, '0});
    script.push_back('{0, 0, lpsd_pkg::FUNC_TICK,       0,  0, 0, 0,  0, 0, '0});

    // Register settings per random phase, extremes first
    lo_plan = '{4'd0,  4'd15, 4'd4,  4'd0, lpsd_pkg::MIN_LEVEL_RESET};
    hi_plan = '{4'd15, 4'd0,  4'd10, 4'd0, lpsd_pkg::MAX_LEVEL_RESET};
    lo_plan[3] = 4'($urandom_range(0, 15));
    hi_plan[3] = 4'($urandom_range(0, 15));
    per_phase  = RANDOM_ITEMS / NUM_PHASES;

    // Hold reset low before releasing it
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed script
    foreach (script[i]) begin
      if (script[i].cfg) begin
        drain();
        write_reg(script[i].cfg_idx, script[i].level);
        cfg_valid_i <= 1'b0;
      end else begin
        send_cmd(script[i].func, script[i].row, script[i].col, script[i].on,
                 script[i].level, script[i].typed, script[i].frame, script[i].pat);
      end
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_reg(lpsd_pkg::CFG_MIN_LEVEL, lo_plan[ph]);
      write_reg(lpsd_pkg::CFG_MAX_LEVEL, hi_plan[ph]);
      cfg_valid_i <= 1'b0;
      for (int n = 0; n < per_phase; n++) begin
        if (ph == NUM_PHASES - 1 && n >= per_phase / 3) quiet = 1'b1;
        // Pause in the middle of phase 2 until every frame is out
        if (ph == 2 && n == per_phase / 2) drain();
        pick = $urandom_range(0, 99);
        if (pick < 40) f = lpsd_pkg::FUNC_TICK;
        else if (pick < 62) f = lpsd_pkg::FUNC_SET_ONOFF;
        else if (pick < 85) f = lpsd_pkg::FUNC_SET_LEVEL;
        else f = lpsd_pkg::FUNC_SET_GLOBAL;
        r  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(0, lpsd_pkg::COLUMN_LENGTH - 1));
        c  = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                         : 2'($urandom_range(0, lpsd_pkg::NUM_COLS - 1));
        on = ($urandom_range(0, 3) != 0);
        lv = 4'($urandom_range(0, 15));
        send_cmd(f, r, c, on, lv, 1'b0, 1'b0, '0);
      end
    end

    // Let the last frames out
    drain();
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== led_pwm_shift_out_driver.f =====
+incdir+rtl/core
rtl/core/lpsd_pkg.sv
rtl/core/lpsd_ram.sv
rtl/core/lpsd_frame_out.sv
rtl/core/led_pwm_shift_out_driver.sv
test/tb_top.sv
